### rtl/hhd_pkg.sv
// Shared types and constants for the hybrid Huffman list decoder.
package hhd_pkg;

  localparam int TREE_NODES_DEF     = 512;
  localparam int HI_BUFFER_BITS_DEF = 16;
  localparam int LO_BUFFER_BITS_DEF = 32;
  localparam int MAX_RESULTS        = 48;
  localparam int CNT_W              = $clog2(MAX_RESULTS + 1);
  localparam logic [4:0] FW_RESET   = 5'd16;
  localparam int IN_TDATA_W         = 120;
  localparam int OUT_TDATA_W        = 32;

  typedef enum logic [1:0] {
    OP_NODE = 2'd0,
    OP_HDR  = 2'd1,
    OP_HI   = 2'd2,
    OP_LO   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HI   = 2'd1,
    PH_LO   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_HDR, S_HI, S_HI_LDW, S_HI_CHK, S_LO, S_DONE
  } bstate_t;

  typedef struct packed {
    op_t         op;
    logic [8:0]  node_index;
    logic [8:0]  left_child;
    logic [8:0]  right_child;
    logic        is_leaf;
    logic [30:0] leaf_value;
    logic [15:0] degree;
    logic [15:0] huff_count;
    logic [15:0] huff_bits;
    logic [7:0]  byte_in;
  } item_t;

  typedef struct packed {
    logic [8:0]  right_child;
    logic [8:0]  left_child;
    logic        is_leaf;
    logic [30:0] leaf_value;
  } node_t;

  typedef struct packed {
    logic [30:0] value;
    logic        from_fallback;
    logic        entry_end;
    logic        empty_entry;
    logic        error;
  } res_t;

endpackage

### rtl/hybrid_huffman_list_decoder_top.sv
// Top level of the hybrid Huffman neighbor-list decoder.
// Input stream: in_tuser carries the op (tree node write, entry header, hi byte,
// lo byte), in_tdata its operands. Tree nodes must be written before entries use
// them. Result stream: one item per decoded value, error or empty-entry marker;
// out_tlast marks the last result caused by an input item. cfg_wr_en/cfg_wr_data
// set the fallback field width; the user must write it only while the block is idle,
// which the block does not enforce. Items enter a two-entry queue and are carried out
// one at a time by the back end. An item passes through the idle, op, hi, lo and done
// states (an entry header also through the header state); a hi-section bit that is
// only skipped takes one hi pass, one that steps the tree adds a check pass, and the
// first bit of a symbol adds a root node reload before that, one node-memory read per
// step; each fallback value takes one lo pass. A result is held until the item's next
// result or its end is reached, then moves to the output register. At most 48 results
// per item; leftover work resumes with later items. Reset (rst_n low, synchronous)
// empties the queue and clears the buffers and entry state; the node memory keeps
// whatever it held. When the receiver stalls, the output register holds its item and
// the back end waits, while the queue keeps accepting until it is full.
module hybrid_huffman_list_decoder_top #(
  parameter int TREE_NODES     = hhd_pkg::TREE_NODES_DEF,
  parameter int HI_BUFFER_BITS = hhd_pkg::HI_BUFFER_BITS_DEF,
  parameter int LO_BUFFER_BITS = hhd_pkg::LO_BUFFER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [4:0]                      cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // node_index, left_child, right_child, is_leaf, leaf_value, degree,
  // huff_count, huff_bits, byte_in
  input  logic [hhd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hhd_pkg::OUT_TDATA_W-1:0] out_tdata,  // value
  // from_fallback, entry_end, empty_entry, error
  output logic [3:0]                      out_tuser,
  output logic                            out_tlast
);

  logic           q_valid, q_pop;
  hhd_pkg::item_t q_item;
  hhd_pkg::res_t  res;

  hhd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  hhd_back #(
    .TREE_NODES     (TREE_NODES),
    .HI_BUFFER_BITS (HI_BUFFER_BITS),
    .LO_BUFFER_BITS (LO_BUFFER_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res),
    .out_last    (out_tlast)
  );

  assign out_tdata = {1'b0, res.value};
  assign out_tuser = {res.error, res.empty_entry, res.entry_end, res.from_fallback};

endmodule

### rtl/hhd_front.sv
// Front end: accepts items, unpacks and classifies them into a two-entry queue.
module hhd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hhd_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          q_valid,
  output hhd_pkg::item_t                q_item,
  input  logic                          q_pop
);

  hhd_pkg::item_t slot_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  hhd_pkg::item_t in_item;
  logic           push;

  always_comb begin
    in_item.op          = hhd_pkg::op_t'(in_tuser);
    in_item.node_index  = in_tdata[8:0];
    in_item.left_child  = in_tdata[17:9];
    in_item.right_child = in_tdata[26:18];
    in_item.is_leaf     = in_tdata[27];
    in_item.leaf_value  = in_tdata[58:28];
    in_item.degree      = in_tdata[74:59];
    in_item.huff_count  = in_tdata[90:75];
    in_item.huff_bits   = in_tdata[106:91];
    in_item.byte_in     = in_tdata[114:107];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### rtl/hhd_back.sv
// Back end: node memory, bit buffers and the decode sequencer with output register.
module hhd_back #(
  parameter int TREE_NODES     = hhd_pkg::TREE_NODES_DEF,
  parameter int HI_BUFFER_BITS = hhd_pkg::HI_BUFFER_BITS_DEF,
  parameter int LO_BUFFER_BITS = hhd_pkg::LO_BUFFER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [4:0]     cfg_wr_data,
  input  logic           q_valid,
  input  hhd_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output hhd_pkg::res_t  out_res,
  output logic           out_last
);

  localparam int AW  = (TREE_NODES > 2) ? $clog2(TREE_NODES) : 1;
  localparam int HB  = HI_BUFFER_BITS;
  localparam int HFW = $clog2(HB + 1);
  localparam int LBW = LO_BUFFER_BITS + 8;
  localparam int LFW = $clog2(LBW + 1);

  hhd_pkg::node_t mem [TREE_NODES];
  hhd_pkg::node_t rd_data_r;
  logic           mem_re, mem_we;
  logic [AW-1:0]  mem_raddr, mem_waddr;
  hhd_pkg::node_t mem_wdata;

  hhd_pkg::bstate_t state_r, state_nxt;
  hhd_pkg::item_t   item_r, item_nxt;
  hhd_pkg::phase_t  phase_r, phase_nxt;
  logic [hhd_pkg::CNT_W-1:0] n_r, n_nxt;
  logic             pend_v_r, pend_v_nxt;
  hhd_pkg::res_t    pend_r, pend_nxt;
  logic             out_v_r, out_v_nxt;
  hhd_pkg::res_t    out_r, out_nxt;
  logic             out_last_r, out_last_nxt;
  logic [HB-1:0]    hi_buf_r, hi_buf_nxt;
  logic [HFW-1:0]   hi_fill_r, hi_fill_nxt;
  logic [LBW-1:0]   lo_buf_r, lo_buf_nxt;
  logic [LFW-1:0]   lo_fill_r, lo_fill_nxt;
  logic [8:0]       walk_r, walk_nxt;
  logic [8:0]       child_r, child_nxt;
  logic             oob_r, oob_nxt;
  logic [15:0]      values_r, values_nxt;
  logic [15:0]      symbols_r, symbols_nxt;
  logic [15:0]      budget_r, budget_nxt;
  hhd_pkg::node_t   cur_r, cur_nxt;
  logic             cur_ok_r, cur_ok_nxt;
  logic [4:0]       fw_r;

  logic can_push, slot_ok, hi_done, need_ldw, lo_done, cap_hit;
  logic emit;
  hhd_pkg::res_t emit_res;
  hhd_pkg::node_t cn;
  logic [8:0]  child;
  logic [31:0] fb_mask;
  logic        hi_fits, lo_fits, lo_needed;

  assign can_push = !out_v_r || out_ready;
  assign slot_ok  = !pend_v_r || can_push;
  assign cap_hit  = (32'(n_r) >= hhd_pkg::MAX_RESULTS);
  assign hi_done  = (phase_r != hhd_pkg::PH_HI) || cap_hit || (budget_r == 16'd0) ||
                    (hi_fill_r == '0);
  assign need_ldw = (symbols_r != 16'd0) && !cur_ok_r && (32'(walk_r) < TREE_NODES);
  assign lo_done  = (phase_r != hhd_pkg::PH_LO) || cap_hit || (values_r == 16'd0) ||
                    (32'(lo_fill_r) < 32'(fw_r));
  assign cn       = oob_r ? '0 : rd_data_r;
  assign child    = hi_buf_r[0] ? cur_r.right_child : cur_r.left_child;
  assign fb_mask  = (32'd1 << fw_r) - 32'd1;
  assign hi_fits  = (32'(hi_fill_r) + 32'd8) <= 32'(HB);
  assign lo_fits  = (32'(lo_fill_r) + 32'd8) <= 32'(LO_BUFFER_BITS);
  assign lo_needed = (phase_r == hhd_pkg::PH_LO) && (values_r != 16'd0) &&
                     (32'(lo_fill_r) < 32'(fw_r));

  assign q_pop     = (state_r == hhd_pkg::S_IDLE) && q_valid;
  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hhd_pkg::S_IDLE:   if (q_valid) state_nxt = hhd_pkg::S_OP;
      hhd_pkg::S_OP: begin
        if (slot_ok) state_nxt = (item_r.op == hhd_pkg::OP_HDR) ? hhd_pkg::S_HDR
                                                                 : hhd_pkg::S_HI;
      end
      hhd_pkg::S_HDR:    if (slot_ok) state_nxt = hhd_pkg::S_HI;
      hhd_pkg::S_HI: begin
        if (slot_ok) begin
          if (hi_done) state_nxt = hhd_pkg::S_LO;
          else if (need_ldw) state_nxt = hhd_pkg::S_HI_LDW;
          else if (symbols_r != 16'd0) state_nxt = hhd_pkg::S_HI_CHK;
        end
      end
      hhd_pkg::S_HI_LDW: state_nxt = hhd_pkg::S_HI;
      hhd_pkg::S_HI_CHK: if (slot_ok) state_nxt = hhd_pkg::S_HI;
      hhd_pkg::S_LO:     if (slot_ok && lo_done) state_nxt = hhd_pkg::S_DONE;
      hhd_pkg::S_DONE:   if (!pend_v_r || can_push) state_nxt = hhd_pkg::S_IDLE;
      default:           state_nxt = hhd_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_nxt    = item_r;
    phase_nxt   = phase_r;
    n_nxt       = n_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    out_v_nxt   = out_v_r && !out_ready;
    out_nxt     = out_r;
    out_last_nxt = out_last_r;
    hi_buf_nxt  = hi_buf_r;
    hi_fill_nxt = hi_fill_r;
    lo_buf_nxt  = lo_buf_r;
    lo_fill_nxt = lo_fill_r;
    walk_nxt    = walk_r;
    child_nxt   = child_r;
    oob_nxt     = oob_r;
    values_nxt  = values_r;
    symbols_nxt = symbols_r;
    budget_nxt  = budget_r;
    cur_nxt     = cur_r;
    cur_ok_nxt  = cur_ok_r;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = AW'(item_r.node_index);
    mem_wdata   = {item_r.right_child, item_r.left_child, item_r.is_leaf,
                   item_r.leaf_value};
    emit        = 1'b0;
    emit_res    = '0;

    case (state_r)
      hhd_pkg::S_IDLE: begin
        if (q_valid) begin
          item_nxt   = q_item;
          n_nxt      = '0;
          cur_ok_nxt = 1'b0;
        end
      end
      hhd_pkg::S_OP: begin
        if (slot_ok) begin
          case (item_r.op)
            hhd_pkg::OP_NODE: begin
              mem_we = (32'(item_r.node_index) < TREE_NODES);
            end
            hhd_pkg::OP_HDR: begin
              if (phase_r != hhd_pkg::PH_IDLE) begin
                emit     = 1'b1;
                emit_res = '{value: '0, from_fallback: 1'b0, entry_end: 1'b1,
                             empty_entry: 1'b0, error: 1'b1};
              end
            end
            hhd_pkg::OP_HI: begin
              if (hi_fits) begin
                hi_buf_nxt  = hi_buf_r | (HB'(item_r.byte_in) << hi_fill_r);
                hi_fill_nxt = hi_fill_r + HFW'(8);
              end else begin
                emit     = 1'b1;
                emit_res = '{value: '0, from_fallback: 1'b0, entry_end: 1'b0,
                             empty_entry: 1'b0, error: 1'b1};
              end
            end
            hhd_pkg::OP_LO: begin
              if (lo_fits || lo_needed) begin
                lo_buf_nxt  = lo_buf_r | (LBW'(item_r.byte_in) << lo_fill_r);
                lo_fill_nxt = lo_fill_r + LFW'(8);
              end else begin
                emit     = 1'b1;
                emit_res = '{value: '0, from_fallback: 1'b0, entry_end: 1'b0,
                             empty_entry: 1'b0, error: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end
      hhd_pkg::S_HDR: begin
        if (slot_ok) begin
          if (item_r.degree == 16'd0) begin
            emit     = 1'b1;
            emit_res = '{value: '0, from_fallback: 1'b0, entry_end: 1'b1,
                         empty_entry: 1'b1, error: 1'b0};
          end
          values_nxt  = item_r.degree;
          symbols_nxt = (item_r.huff_count < item_r.degree) ? item_r.huff_count
                                                            : item_r.degree;
          budget_nxt  = item_r.huff_bits;
          walk_nxt    = '0;
          cur_ok_nxt  = 1'b0;
          phase_nxt   = hhd_pkg::PH_HI;
        end
      end
      hhd_pkg::S_HI: begin
        if (slot_ok) begin
          if (phase_r == hhd_pkg::PH_HI && !cap_hit && budget_r == 16'd0) begin
            // budget spent: a symbol cut short becomes an error result
            if (symbols_r != 16'd0 && walk_r != 9'd0) begin
              values_nxt = values_r - 16'd1;
              emit       = 1'b1;
              emit_res   = '{value: '0, from_fallback: 1'b0,
                             entry_end: (values_nxt == 16'd0),
                             empty_entry: 1'b0, error: 1'b1};
            end
            walk_nxt    = '0;
            cur_ok_nxt  = 1'b0;
            symbols_nxt = '0;
            phase_nxt   = (values_nxt != 16'd0) ? hhd_pkg::PH_LO : hhd_pkg::PH_IDLE;
          end else if (!hi_done) begin
            if (need_ldw) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(walk_r);
            end else begin
              if (symbols_r != 16'd0 && !cur_ok_r) begin
                cur_nxt = '0;  // walk sits beyond the tree
              end
              hi_buf_nxt  = hi_buf_r >> 1;
              hi_fill_nxt = hi_fill_r - HFW'(1);
              budget_nxt  = budget_r - 16'd1;
              if (symbols_r != 16'd0) begin
                child_nxt = cur_ok_r ? child : 9'd0;
                oob_nxt   = (32'(child_nxt) >= TREE_NODES);
                mem_re    = 1'b1;
                mem_raddr = AW'(child_nxt);
              end
            end
          end
        end
      end
      hhd_pkg::S_HI_LDW: begin
        cur_nxt    = rd_data_r;
        cur_ok_nxt = 1'b1;
      end
      hhd_pkg::S_HI_CHK: begin
        if (slot_ok) begin
          if (cn.is_leaf) begin
            symbols_nxt = symbols_r - 16'd1;
            values_nxt  = values_r - 16'd1;
            walk_nxt    = '0;
            cur_ok_nxt  = 1'b0;
            emit        = 1'b1;
            emit_res    = '{value: cn.leaf_value, from_fallback: 1'b0,
                            entry_end: (values_nxt == 16'd0),
                            empty_entry: 1'b0, error: 1'b0};
          end else begin
            walk_nxt   = child_r;
            cur_nxt    = cn;
            cur_ok_nxt = 1'b1;
          end
        end
      end
      hhd_pkg::S_LO: begin
        if (slot_ok) begin
          if (phase_r == hhd_pkg::PH_LO && !cap_hit && values_r == 16'd0) begin
            phase_nxt = hhd_pkg::PH_IDLE;
          end else if (!lo_done) begin
            lo_buf_nxt  = lo_buf_r >> fw_r;
            lo_fill_nxt = lo_fill_r - LFW'(fw_r);
            values_nxt  = values_r - 16'd1;
            emit        = 1'b1;
            emit_res    = '{value: lo_buf_r[30:0] & fb_mask[30:0], from_fallback: 1'b1,
                            entry_end: (values_nxt == 16'd0),
                            empty_entry: 1'b0, error: 1'b0};
            if (values_nxt == 16'd0) phase_nxt = hhd_pkg::PH_IDLE;
          end
        end
      end
      hhd_pkg::S_DONE: begin
        if (pend_v_r && can_push) begin
          out_v_nxt    = 1'b1;
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
        end
      end
      default: ;
    endcase

    // the held result goes out once a newer one proves it is not the last
    if (emit) begin
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = emit_res;
      n_nxt      = n_r + hhd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    child_r    <= child_nxt;
    oob_r      <= oob_nxt;
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hhd_pkg::S_IDLE;
      phase_r   <= hhd_pkg::PH_IDLE;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      hi_buf_r  <= '0;
      hi_fill_r <= '0;
      lo_buf_r  <= '0;
      lo_fill_r <= '0;
      walk_r    <= '0;
      values_r  <= '0;
      symbols_r <= '0;
      budget_r  <= '0;
      cur_ok_r  <= 1'b0;
      fw_r      <= hhd_pkg::FW_RESET;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
      hi_buf_r  <= hi_buf_nxt;
      hi_fill_r <= hi_fill_nxt;
      lo_buf_r  <= lo_buf_nxt;
      lo_fill_r <= lo_fill_nxt;
      walk_r    <= walk_nxt;
      values_r  <= values_nxt;
      symbols_r <= symbols_nxt;
      budget_r  <= budget_nxt;
      cur_ok_r  <= cur_ok_nxt;
      if (cfg_wr_en) fw_r <= cfg_wr_data;
    end
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for the hybrid Huffman neighbor-list decoder.
module testbench;

  typedef struct {
    hhd_pkg::res_t r;
    bit            last;
  } decoded_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [4:0]                      cfg_wr_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [hhd_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [hhd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [3:0]                      out_tuser;
  logic                            out_tlast;

  hybrid_huffman_list_decoder_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // decoder shadow state
  hhd_pkg::node_t  tree_mem[512];
  bit              node_known[512];
  int              known_nodes[$];
  logic [15:0]     hi_buf;
  int              hi_fill;
  logic [63:0]     lo_buf;
  int              lo_fill;
  logic [8:0]      walk_at;
  int              values_left;
  int              symbols_left;
  int              budget_left;
  hhd_pkg::phase_t entry_phase;
  int              fb_width;

  decoded_t    pending_results[$];
  decoded_t    item_results[$];
  int          mismatches;
  int          send_idle_pct;
  int          rcv_stall_pct;
  int          hold_request;
  int          hold_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void add_result(logic [30:0] v, bit fb, bit fin, bit empty, bit err);
    decoded_t d;
    d.r.value = v;
    d.r.from_fallback = fb;
    d.r.entry_end = fin;
    d.r.empty_entry = empty;
    d.r.error = err;
    d.last = 1'b0;
    item_results.insert(item_results.size(), d);
  endfunction

  function automatic void walk_hi();
    hhd_pkg::node_t nd;
    hhd_pkg::node_t cn;
    logic [8:0] child;
    bit b;
    while (entry_phase == hhd_pkg::PH_HI && item_results.size() < hhd_pkg::MAX_RESULTS) begin
      if (budget_left == 0) begin
        if (symbols_left > 0 && walk_at != 0) begin
          values_left--;
          add_result('0, 0, values_left == 0, 0, 1);
        end
        walk_at = '0;
        symbols_left = 0;
        entry_phase = (values_left != 0) ? hhd_pkg::PH_LO : hhd_pkg::PH_IDLE;
        break;
      end
      if (hi_fill == 0) break;
      b = hi_buf[0];
      hi_buf = hi_buf >> 1;
      hi_fill--;
      budget_left--;
      if (symbols_left > 0) begin
        nd = tree_mem[walk_at];
        child = b ? nd.right_child : nd.left_child;
        cn = tree_mem[child];
        if (cn.is_leaf) begin
          symbols_left--;
          values_left--;
          walk_at = '0;
          add_result(cn.leaf_value, 0, values_left == 0, 0, 0);
        end else begin
          walk_at = child;
        end
      end
    end
  endfunction

  function automatic void read_fallback();
    logic [63:0] v;
    while (entry_phase == hhd_pkg::PH_LO && item_results.size() < hhd_pkg::MAX_RESULTS) begin
      if (values_left == 0) begin
        entry_phase = hhd_pkg::PH_IDLE;
        break;
      end
      if (lo_fill < fb_width) break;
      v = '0;
      if (fb_width > 0) begin
        v = lo_buf & ((64'd1 << fb_width) - 64'd1);
        lo_buf = lo_buf >> fb_width;
        lo_fill -= fb_width;
      end
      values_left--;
      add_result(v[30:0], 1, values_left == 0, 0, 0);
      if (values_left == 0) entry_phase = hhd_pkg::PH_IDLE;
    end
  endfunction

  function automatic void decode_item(hhd_pkg::item_t it);
    bit fits;
    bit needed;
    item_results.delete();
    case (it.op)
      hhd_pkg::OP_NODE: begin
        tree_mem[it.node_index] = '{it.right_child, it.left_child, it.is_leaf,
                                    it.leaf_value};
        if (!node_known[it.node_index])
          known_nodes.insert(known_nodes.size(), int'(it.node_index));
        node_known[it.node_index] = 1'b1;
      end
      hhd_pkg::OP_HDR: begin
        if (entry_phase != hhd_pkg::PH_IDLE) add_result('0, 0, 1, 0, 1);
        if (it.degree == 0) add_result('0, 0, 1, 1, 0);
        values_left = it.degree;
        symbols_left = (it.huff_count < it.degree) ? it.huff_count : it.degree;
        budget_left = it.huff_bits;
        walk_at = '0;
        entry_phase = hhd_pkg::PH_HI;
      end
      hhd_pkg::OP_HI: begin
        if (hi_fill + 8 <= 16) begin
          hi_buf = hi_buf | (16'(it.byte_in) << hi_fill);
          hi_fill += 8;
        end else begin
          add_result('0, 0, 0, 0, 1);
        end
      end
      default: begin
        fits = lo_fill + 8 <= 32;
        needed = entry_phase == hhd_pkg::PH_LO && values_left > 0 && lo_fill < fb_width;
        if (fits || needed) begin
          lo_buf = lo_buf | (64'(it.byte_in) << lo_fill);
          lo_fill += 8;
        end else begin
          add_result('0, 0, 0, 0, 1);
        end
      end
    endcase
    walk_hi();
    read_fallback();
    if (item_results.size() > 0) item_results[item_results.size()-1].last = 1'b1;
    foreach (item_results[i]) pending_results.insert(pending_results.size(), item_results[i]);
  endfunction

  // Leaves in_tvalid high on return; the next call overwrites data in the same step.
  task automatic send_item(hhd_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {5'b0, it.byte_in, it.huff_bits, it.huff_count, it.degree, it.leaf_value,
                  it.is_leaf, it.right_child, it.left_child, it.node_index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_item(it);
  endtask

  task automatic put_node(int idx, int l, int r, bit leaf, logic [30:0] v);
    hhd_pkg::item_t it;
    it = '0;
    it.op = hhd_pkg::OP_NODE;
    it.node_index = 9'(idx);
    it.left_child = 9'(l);
    it.right_child = 9'(r);
    it.is_leaf = leaf;
    it.leaf_value = v;
    send_item(it);
  endtask

  task automatic put_header(int deg, int hc, int hb);
    hhd_pkg::item_t it;
    it = '0;
    it.op = hhd_pkg::OP_HDR;
    it.degree = 16'(deg);
    it.huff_count = 16'(hc);
    it.huff_bits = 16'(hb);
    send_item(it);
  endtask

  task automatic put_byte(hhd_pkg::op_t op, logic [7:0] b);
    hhd_pkg::item_t it;
    it = '0;
    it.op = op;
    it.byte_in = b;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_width(int w);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 5'(w);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    fb_width = w;
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    decoded_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result data=%h user=%h", out_tdata, out_tuser);
      end else begin
        e = pending_results.pop_front();
        if (out_tdata !== {1'b0, e.r.value} ||
            out_tuser !== {e.r.error, e.r.empty_entry, e.r.entry_end, e.r.from_fallback} ||
            out_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp value=%h fb=%b end=%b empty=%b err=%b last=%b;",
                      " got data=%h user=%b last=%b"},
                     e.r.value, e.r.from_fallback, e.r.entry_end, e.r.empty_entry, e.r.error,
                     e.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
    if (hold_request > 0) begin
      hold_count = hold_request;
      hold_request = 0;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic test_tree_load();
    put_node(0, 1, 2, 0, '0);
    put_node(1, 0, 0, 1, 31'h7FFFFFFF);
    put_node(2, 3, 4, 0, '0);
    put_node(3, 0, 0, 1, '0);
    put_node(4, 511, 511, 1, 31'd5);
    put_node(511, 3, 4, 0, 31'h2AAAAAAA);
  endtask

  task automatic test_directed_entries();
    put_header(0, 0, 8);        // empty entry, budget still skipped
    put_byte(hhd_pkg::OP_HI, 8'hFF);
    put_header(3, 5, 16);       // count cut to degree
    put_byte(hhd_pkg::OP_HI, 8'b1110_1100);
    put_byte(hhd_pkg::OP_HI, 8'h00);
    put_header(3, 3, 4);        // budget runs out mid-symbol
    put_byte(hhd_pkg::OP_HI, 8'b0000_1010);
    put_byte(hhd_pkg::OP_LO, 8'h34);
    put_byte(hhd_pkg::OP_LO, 8'h12);
    put_byte(hhd_pkg::OP_LO, 8'hFF);
    put_byte(hhd_pkg::OP_LO, 8'h00);
    put_header(4, 4, 1);        // budget short of count
    put_byte(hhd_pkg::OP_HI, 8'h00);
    put_header(65535, 65535, 65535);
    put_header(2, 0, 0);        // abandons the previous entry
    put_byte(hhd_pkg::OP_HI, 8'h01);
    put_byte(hhd_pkg::OP_HI, 8'h02);
    put_byte(hhd_pkg::OP_HI, 8'h03);     // hi buffer overflow
    repeat (6) put_byte(hhd_pkg::OP_LO, 8'hA5);  // lo buffer overflow
  endtask

  task automatic test_zero_width();
    set_width(0);
    put_header(60, 0, 0);       // more than one item's worth of results
    put_byte(hhd_pkg::OP_LO, 8'h00);
    set_width(31);
    put_header(2, 0, 0);
    repeat (9) put_byte(hhd_pkg::OP_LO, 8'($urandom_range(255)));
    set_width(1);
    put_header(5, 0, 0);
    put_byte(hhd_pkg::OP_LO, 8'h15);
  endtask

  task automatic random_traffic(int n_items);
    hhd_pkg::item_t it;
    int sent;
    int deg;
    int hb;
    int hi_bytes;
    int nbytes;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          it = '0;
          it.op = hhd_pkg::OP_NODE;
          it.node_index = 9'($urandom_range(511));
          it.left_child = 9'(known_nodes[$urandom_range(known_nodes.size()-1)]);
          it.right_child = 9'(known_nodes[$urandom_range(known_nodes.size()-1)]);
          it.is_leaf = 1'($urandom_range(1));
          it.leaf_value = 31'($urandom() >> 1);
          send_item(it);
          sent++;
        end
        1: begin
          it = '0;
          it.op = hhd_pkg::op_t'($urandom_range(3));
          it.node_index = 9'($urandom_range(511));
          it.left_child = 9'(known_nodes[$urandom_range(known_nodes.size()-1)]);
          it.right_child = 9'(known_nodes[$urandom_range(known_nodes.size()-1)]);
          it.degree = 16'($urandom_range(65535));
          it.huff_count = 16'($urandom_range(65535));
          it.huff_bits = 16'($urandom_range(65535));
          it.byte_in = 8'($urandom_range(255));
          send_item(it);
          sent++;
        end
        default: begin
          deg = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(8);
          hb = $urandom_range(40);
          put_header(deg, $urandom_range(deg + 2), hb);
          hi_bytes = (hb + 7) / 8 + $urandom_range(1);
          repeat (hi_bytes) put_byte(hhd_pkg::OP_HI, 8'($urandom_range(255)));
          nbytes = (deg * fb_width + 7) / 8 + $urandom_range(1);
          repeat (nbytes) put_byte(hhd_pkg::OP_LO, 8'($urandom_range(255)));
          sent += 1 + hi_bytes + nbytes;
        end
      endcase
    end
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  rcv_stall_pct = 0;
    set_width(7);
    random_traffic(60);
    send_idle_pct = 66; rcv_stall_pct = 0;
    set_width(3);
    random_traffic(60);
    send_idle_pct = 0;  rcv_stall_pct = 66;
    set_width(12);
    random_traffic(60);
    send_idle_pct = 20; rcv_stall_pct = 20;
    set_width($urandom_range(1, 31));
    random_traffic(60);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;  rcv_stall_pct = 0;
    set_width(4);
    hold_request = 400;
    random_traffic(30);
    wait_drained();
    random_traffic(15);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    hi_buf = '0; hi_fill = 0; lo_buf = '0; lo_fill = 0;
    walk_at = '0; values_left = 0; symbols_left = 0; budget_left = 0;
    entry_phase = hhd_pkg::PH_IDLE;
    fb_width = hhd_pkg::FW_RESET;
    mismatches = 0;
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_request = 0;
    hold_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_width(16);
    test_tree_load();
    test_directed_entries();
    test_zero_width();
    test_random_phases();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
